### rtl/button_event_qualifier_unit_defines.svh
// Assertion macros of the button event qualifier checker
`ifndef BUTTON_EVENT_QUALIFIER_UNIT_DEFINES_SVH
`define BUTTON_EVENT_QUALIFIER_UNIT_DEFINES_SVH

// same-cycle implication, idle during reset
`define BEQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button event qualifier: implication check failed");

// next-cycle implication, idle during reset
`define BEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button event qualifier: next-cycle check failed");

`endif

### rtl/beq_pkg.sv
// Types and constants of the button event qualifier
package beq_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int CFG_WIDTH       = 16;
   localparam int CMP_WIDTH       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int MODE_WIDTH      = 3;
   localparam int EVENT_WIDTH     = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic                 RST_ACTIVE_LEVEL = 1'b1;
   localparam logic [CFG_WIDTH-1:0] RST_LONG_TICKS   = CFG_WIDTH'(10);
   localparam logic [CFG_WIDTH-1:0] RST_DELAY        = CFG_WIDTH'(10);
   localparam logic [CFG_WIDTH-1:0] RST_PERIOD       = CFG_WIDTH'(10);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACTIVE_LEVEL = 8'd0,
      CSR_LONG_TICKS   = 8'd1,
      CSR_DELAY        = 8'd2,
      CSR_PERIOD       = 8'd3
   } csr_index_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_EDGE    = 3'd0,
      MODE_REPEAT  = 3'd1,
      MODE_RELEASE = 3'd2,
      MODE_TIMED   = 3'd3,
      MODE_LEVEL   = 3'd4
   } mode_type;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_NONE  = 2'd0,
      EV_PRESS = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

endpackage

### rtl/button_event_qualifier_unit.sv
// Button event qualifier: press, repeat, release, timed release and level events
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------
//  req     | in  | req_valid/req_stall  | req_level, req_mode
//  rsp     | out | rsp_valid/rsp_stall  | rsp_event_res
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One item per cycle while req_stall is low; its result is registered.
// The state update is a single compare and increment between input and result register.
// A skid register holds one result while rsp is stalled; req_stall rises only once it fills.
// Synchronous reset clears state and restores configuration defaults.
module button_event_qualifier_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_level,
   input  logic [beq_pkg::MODE_WIDTH-1:0]      req_mode,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [beq_pkg::EVENT_WIDTH-1:0]     rsp_event_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [beq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [beq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CW = beq_pkg::COUNT_WIDTH;
   localparam int MW = beq_pkg::CMP_WIDTH;

   logic                          active_level_ff;
   logic [beq_pkg::CFG_WIDTH-1:0] long_ticks_ff, delay_ff, period_ff;

   logic          was_pressed_ff, was_pressed_in;
   logic [CW-1:0] hold_ff, hold_in;
   logic [CW-1:0] phase_ff, phase_in;

   logic                               out_valid_ff, skid_valid_ff;
   logic [beq_pkg::EVENT_WIDTH-1:0]    out_ev_ff, skid_ev_ff;
   beq_pkg::event_type                 ev;

   logic          accept, out_free;
   logic          pressed, press_edge, release_edge, past_delay, repeat_fire;
   logic [MW-1:0] period;
   logic [MW:0]   phase_next;

   assign csr_ready     = 1'b1;
   assign req_stall     = skid_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = out_ev_ff;

   assign accept   = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;

   assign pressed      = (req_level == active_level_ff);
   assign press_edge   = pressed && !was_pressed_ff;
   assign release_edge = !pressed && was_pressed_ff;

   always_comb begin
      if (!pressed) begin
         hold_in = '0;
      end else if (press_edge) begin
         hold_in = CW'(1);
      end else if (hold_ff != beq_pkg::COUNT_MAX) begin
         hold_in = hold_ff + CW'(1);
      end else begin
         hold_in = hold_ff;
      end
   end

   assign past_delay = pressed && !press_edge && (MW'(hold_in) > MW'(delay_ff));
   assign period     = (period_ff == '0) ? MW'(1) : MW'(period_ff);
   assign phase_next = (MW+1)'(phase_ff) + (MW+1)'(1);
   assign repeat_fire = past_delay && (phase_ff == '0);

   always_comb begin
      if (!past_delay || phase_next >= (MW+1)'(period)) begin
         phase_in = '0;
      end else begin
         phase_in = phase_next[CW-1:0];
      end
   end

   assign was_pressed_in = pressed;

   always_comb begin
      ev = beq_pkg::EV_NONE;
      unique case (beq_pkg::mode_type'(req_mode))
         beq_pkg::MODE_EDGE: begin
            if (press_edge) ev = beq_pkg::EV_PRESS;
         end
         beq_pkg::MODE_REPEAT: begin
            if (press_edge || repeat_fire) ev = beq_pkg::EV_PRESS;
         end
         beq_pkg::MODE_RELEASE: begin
            if (release_edge) ev = beq_pkg::EV_PRESS;
         end
         beq_pkg::MODE_TIMED: begin
            if (release_edge) begin
               ev = (MW'(hold_ff) > MW'(long_ticks_ff)) ? beq_pkg::EV_LONG
                                                        : beq_pkg::EV_PRESS;
            end
         end
         default: begin
            if (pressed) ev = beq_pkg::EV_PRESS;
         end
      endcase
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= beq_pkg::RST_ACTIVE_LEVEL;
         long_ticks_ff   <= beq_pkg::RST_LONG_TICKS;
         delay_ff        <= beq_pkg::RST_DELAY;
         period_ff       <= beq_pkg::RST_PERIOD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            beq_pkg::CSR_ACTIVE_LEVEL: active_level_ff <= csr_wdata[0];
            beq_pkg::CSR_LONG_TICKS:   long_ticks_ff   <= csr_wdata[beq_pkg::CFG_WIDTH-1:0];
            beq_pkg::CSR_DELAY:        delay_ff        <= csr_wdata[beq_pkg::CFG_WIDTH-1:0];
            beq_pkg::CSR_PERIOD:       period_ff       <= csr_wdata[beq_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // button state
   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff <= 1'b0;
         hold_ff        <= '0;
         phase_ff       <= '0;
      end else if (accept) begin
         was_pressed_ff <= was_pressed_in;
         hold_ff        <= hold_in;
         phase_ff       <= phase_in;
      end
   end

   // result register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_ev_ff     <= skid_ev_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
            out_ev_ff    <= ev;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
         skid_ev_ff    <= ev;
      end
   end

endmodule

### rtl/beq_checker.sv
// Port-level checks of the button event qualifier, bound to the top level
`include "button_event_qualifier_unit_defines.svh"

module beq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_level,
   input logic [beq_pkg::MODE_WIDTH-1:0]      req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [beq_pkg::EVENT_WIDTH-1:0]     rsp_event_res,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [beq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [beq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic req_take;
   logic unused_ok;

   assign req_take  = req_valid && !req_stall;
   assign unused_ok = req_level ^ (|req_mode) ^ csr_valid ^ csr_ready ^ (|csr_index)
                      ^ (|csr_wdata);

   // no event code beyond long press
   `BEQ_ASSERT_IMPL(a_event_code, clock, reset, rsp_valid,
      rsp_event_res != 2'd3 || unused_ok != unused_ok)

   // input only backs up behind a stalled result
   `BEQ_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, $past(rsp_valid && rsp_stall))

   // an accepted item is followed by a valid result in the next cycle
   `BEQ_ASSERT_NEXT(a_result_follows, clock, reset, req_take, rsp_valid)

   // no result appears without an item
   `BEQ_ASSERT_NEXT(a_no_phantom, clock, reset, !rsp_valid && !req_take, !rsp_valid)

   // stalled result holds
   `BEQ_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_event_res))

endmodule

bind button_event_qualifier_unit beq_checker u_beq_checker (.*);
